@@ rtl/core/shs_pkg.sv @@
// Shared types, constants and round functions of the SHA-256 stream hasher.
package shs_pkg;

  // Round constants, round 0 first.
  localparam logic [31:0] SHS_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Initial hash value; element 0 is H0.
  localparam logic [7:0][31:0] SHS_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] SHS_PAD_BYTE = 8'h80;
  localparam logic [5:0] SHS_LEN_POS  = 6'd56;  // first byte of the length field
  localparam logic [5:0] SHS_LAST_POS = 6'd63;
  localparam logic [5:0] SHS_LAST_RND = 6'd63;
  localparam logic [2:0] SHS_LAST_IDX = 3'd7;

  localparam logic FUNC_ABSORB = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic       absorb;     // write byte at fill, bump fill and byte count
    logic       pad;        // 0x80 at fill, zero bytes above it
    logic       len_wr;     // bit length into words 14 and 15
    logic       clr_win;    // zero the whole block
    logic       start;      // load working vars from hash words
    logic       round;      // one compression round
    logic       add;        // fold working vars into hash words
    logic       final_rst;  // back to initial hash, fill and count zero
    logic [5:0] rnd;
    logic [2:0] idx;
  } shs_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic fill_last;  // next byte completes the block
    logic no_room;    // padding byte leaves no room for the length
  } shs_stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] ch_fn(input logic [31:0] e, input logic [31:0] f,
                                        input logic [31:0] g);
    ch_fn = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] maj_fn(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c);
    maj_fn = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

@@ rtl/core/shs_if.sv @@
// Valid/ready channel interfaces for the request and digest streams.
interface shs_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface shs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

@@ rtl/core/shs_dp.sv @@
// Datapath: block window, message schedule, round logic, hash words and byte count.
module shs_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        data_byte,
  input  shs_pkg::shs_cmd_t cmd,
  output shs_pkg::shs_stat_t stat,
  output logic [31:0]       digest_word
);
  import shs_pkg::*;

  // Block window: word 0 is the schedule word of the current round.
  logic [15:0][31:0] win_r, win_nxt;
  logic [7:0][31:0]  v_r, v_nxt;
  logic [7:0][31:0]  h_r, h_nxt;
  logic [5:0]        fill_r, fill_nxt;
  logic [60:0]       cnt_r, cnt_nxt;

  logic [31:0] w_new, t1, t2;
  logic [63:0] bit_len;

  assign bit_len = {cnt_r, 3'b000};

  always_comb begin
    w_new = win_r[0] + sml_sig0(win_r[1]) + win_r[9] + sml_sig1(win_r[14]);
    t1    = v_r[7] + big_sig1(v_r[4]) + ch_fn(v_r[4], v_r[5], v_r[6])
          + SHS_K[cmd.rnd] + win_r[0];
    t2    = big_sig0(v_r[0]) + maj_fn(v_r[0], v_r[1], v_r[2]);
  end

  always_comb begin
    win_nxt = win_r;
    if (cmd.clr_win) begin
      win_nxt = '0;
    end
    for (int b = 0; b < 64; b++) begin
      if (cmd.absorb && 6'(b) == fill_r) begin
        win_nxt[b / 4][31 - 8 * (b % 4) -: 8] = data_byte;
      end
      if (cmd.pad && 6'(b) == fill_r) begin
        win_nxt[b / 4][31 - 8 * (b % 4) -: 8] = SHS_PAD_BYTE;
      end
      if (cmd.pad && 6'(b) > fill_r) begin
        win_nxt[b / 4][31 - 8 * (b % 4) -: 8] = 8'h00;
      end
    end
    if (cmd.len_wr) begin
      win_nxt[14] = bit_len[63:32];
      win_nxt[15] = bit_len[31:0];
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = win_r[i + 1];
      end
      win_nxt[15] = w_new;
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (cmd.start) begin
      v_nxt = h_r;
    end else if (cmd.round) begin
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end
  end

  always_comb begin
    h_nxt    = h_r;
    fill_nxt = fill_r;
    cnt_nxt  = cnt_r;
    if (cmd.add) begin
      for (int i = 0; i < 8; i++) begin
        h_nxt[i] = h_r[i] + v_r[i];
      end
    end
    if (cmd.absorb) begin
      fill_nxt = fill_r + 6'd1;
      cnt_nxt  = cnt_r + 61'd1;
    end
    if (cmd.final_rst) begin
      h_nxt    = SHS_IV;
      fill_nxt = '0;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r    <= SHS_IV;
      fill_r <= '0;
      cnt_r  <= '0;
    end else begin
      h_r    <= h_nxt;
      fill_r <= fill_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    v_r   <= v_nxt;
  end

  assign stat.fill_last = (fill_r == SHS_LAST_POS);
  assign stat.no_room   = (fill_r >= SHS_LEN_POS);
  assign digest_word    = h_r[cmd.idx];

endmodule

@@ rtl/core/shs_ctrl.sv @@
// Controller: request accept, round sequencing, finish padding and digest emit.
module shs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_func,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  shs_pkg::shs_stat_t stat,
  output shs_pkg::shs_cmd_t  cmd
);
  import shs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_FIN2  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       fin_r, fin_nxt;   // finish in progress
  logic       two_r, two_nxt;   // length goes in a second padding block

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    fin_nxt   = fin_r;
    two_nxt   = two_r;
    cmd       = '0;
    cmd.rnd   = rnd_r;
    cmd.idx   = idx_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rnd_nxt = '0;
          if (in_func == FUNC_FINISH) begin
            cmd.pad   = 1'b1;
            cmd.start = 1'b1;
            fin_nxt   = 1'b1;
            if (stat.no_room) begin
              two_nxt = 1'b1;
            end else begin
              cmd.len_wr = 1'b1;
            end
            state_nxt = S_ROUND;
          end else begin
            cmd.absorb = 1'b1;
            if (stat.fill_last) begin
              cmd.start = 1'b1;
              state_nxt = S_ROUND;
            end
          end
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == SHS_LAST_RND) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (two_r) begin
          state_nxt = S_FIN2;
        end else if (fin_r) begin
          idx_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FIN2: begin
        cmd.clr_win = 1'b1;
        cmd.len_wr  = 1'b1;
        cmd.start   = 1'b1;
        two_nxt     = 1'b0;
        rnd_nxt     = '0;
        state_nxt   = S_ROUND;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == SHS_LAST_IDX) begin
            cmd.final_rst = 1'b1;
            fin_nxt       = 1'b0;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rnd_r   <= '0;
      idx_r   <= '0;
      fin_r   <= 1'b0;
      two_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      fin_r   <= fin_nxt;
      two_r   <= two_nxt;
    end
  end

  a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request accepted while digest pending");

  a_last_round_adds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && rnd_r == SHS_LAST_RND) |=> (state_r == S_ADD))
    else $error("round 63 not followed by hash add");

  a_second_block_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
    two_r |-> fin_r)
    else $error("second padding block outside finish");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.absorb, cmd.round, cmd.add, cmd.final_rst, cmd.clr_win}))
    else $error("conflicting datapath commands");

  a_emit_only_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> fin_r)
    else $error("digest word outside finish");

endmodule

@@ rtl/core/sha256_stream_hasher_core.sv @@
// Top level of the SHA-256 stream hasher: controller plus datapath.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+-----------------------------------------
//   in_ch   | in  | valid/ready request | func (absorb/finish), data_byte
//   out_ch  | out | valid/ready request | digest_word, word_index, last_word
//
// An absorb request is taken in S_IDLE; the 64th byte of a block also starts the
// compression rounds and the hash add, and no request is taken until they end.
// A finish pads the block and runs the rounds and hash add (twice when the length
// spills into a second block), then eight digest requests, one per cycle while
// out_ch.ready holds.
// The single shared round unit runs one SHA-256 round per cycle.
// Reset (rst_n low, synchronous) loads the initial hash and clears the fill
// and byte count. in_ch.ready is high only when no block or digest is pending;
// a stalled digest word holds with its index until taken.
module sha256_stream_hasher_core (
  input logic      clk,
  input logic      rst_n,
  shs_in_if.sink   in_ch,
  shs_out_if.source out_ch
);
  import shs_pkg::*;

  shs_cmd_t  cmd;
  shs_stat_t stat;

  // Sequencer: accepts requests, steps rounds, runs padding and emits words.
  shs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Block window, schedule, round logic and hash state.
  shs_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .data_byte   (in_ch.data_byte),
    .cmd         (cmd),
    .stat        (stat),
    .digest_word (out_ch.digest_word)
  );

  // Word index comes straight from the emit counter.
  assign out_ch.word_index = cmd.idx;
  assign out_ch.last_word  = (cmd.idx == SHS_LAST_IDX);

endmodule

@@ bench/shs_digest_checker.sv @@
// Digest checker: tracks accepted requests, predicts SHA-256 digests, compares result words.
module shs_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  shs_in_if           in_mon,
  shs_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned digests_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import shs_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] CHAIN_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [31:0]  chain [8];
  logic [7:0]   blk [64];
  int unsigned  blk_fill;
  logic [60:0]  msg_bytes;
  digest_word_t digest_q [$];

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    logic [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] digest mismatch: %s", $realtime, what);
    fail_count = fail_count + 1;
  endtask

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int t = 0; t < 16; t++) w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                chain[4], chain[5], chain[6], chain[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_CONST[t] + w[t];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) chain[i] = CHAIN_INIT[i];
    blk_fill  = 0;
    msg_bytes = '0;
  endtask

  task automatic predict_request(input logic func, input logic [7:0] data_byte);
    logic [63:0]  bit_len;
    digest_word_t dw;
    if (func == FUNC_ABSORB) begin
      blk[blk_fill] = data_byte;
      blk_fill++;
      msg_bytes = msg_bytes + 61'd1;
      if (blk_fill == 64) begin
        compress_block();
        blk_fill = 0;
      end
    end else begin
      bit_len = {msg_bytes, 3'b000};
      blk[blk_fill] = 8'h80;
      blk_fill++;
      // no room left for the length: spill into a second block
      if (blk_fill > 56) begin
        for (int i = blk_fill; i < 64; i++) blk[i] = 8'h00;
        compress_block();
        blk_fill = 0;
      end
      for (int i = blk_fill; i < 56; i++) blk[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk[56+i] = bit_len[8*(7-i) +: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        dw.word  = chain[i];
        dw.index = 3'(i);
        dw.last  = (i == 7);
        digest_q.push_back(dw);
      end
      restart_message();
    end
  endtask

  task automatic check_digest_word();
    digest_word_t want;
    if (digest_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected word %08h index %0d",
                              out_mon.digest_word, out_mon.word_index));
    end else begin
      want = digest_q.pop_front();
      if (out_mon.digest_word !== want.word)
        flag_mismatch($sformatf("digest_word %08h, want %08h", out_mon.digest_word, want.word));
      if (out_mon.word_index !== want.index)
        flag_mismatch($sformatf("word_index %0d, want %0d", out_mon.word_index, want.index));
      if (out_mon.last_word !== want.last)
        flag_mismatch($sformatf("last_word %0b, want %0b", out_mon.last_word, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_message();
      digest_q.delete();
      digests_owed <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) predict_request(in_mon.func, in_mon.data_byte);
      if (out_mon.valid && out_mon.ready) check_digest_word();
      digests_owed <= digest_q.size();
    end
  end

endmodule

@@ bench/tb_sha256_stream_hasher_core.sv @@
// Testbench top: drives byte/finish requests into the hasher and gives the verdict.
module tb_sha256_stream_hasher_core;
  timeunit 1ns;
  timeprecision 1ps;
  import shs_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  // Tail after the last digest word: longer than a two-block finish.
  localparam int unsigned DRAIN_CYCLES    = 160;
  localparam int unsigned PHASE_REQUESTS  = 50;

  logic        clk;
  logic        rst_n;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned cycle_count;
  int unsigned sent;
  int unsigned fail_count;
  int unsigned digests_owed;

  shs_in_if  in_ch ();
  shs_out_if out_ch ();

  sha256_stream_hasher_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  shs_digest_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .digests_owed (digests_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_sha256_stream_hasher_core NOT OK");
      $finish;
    end
  end

  // One request: optional idle cycles first, then hold valid until taken.
  // valid is only lowered when an idle cycle is actually inserted, so
  // back-to-back requests keep it high without a low/high pair in one step.
  task automatic send_request(input logic func, input logic [7:0] data_byte);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= func;
    in_ch.data_byte <= data_byte;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // Message of random bytes, closed by a finish whose data byte is noise.
  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_request(FUNC_ABSORB, 8'($urandom_range(255)));
    send_request(FUNC_FINISH, 8'($urandom_range(255)));
  endtask

  // Many short messages so digests come often; a good share sits on the
  // padding edges (55/56 bytes is where the length spills into a second
  // block, 63/64 where a full block is compressed before the finish).
  function automatic int unsigned pick_length();
    int unsigned edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    int unsigned bucket;
    bucket = $urandom_range(9);
    if (bucket < 4) return $urandom_range(12);
    if (bucket < 7) return edges[$urandom_range(9)];
    return $urandom_range(140);
  endfunction

  initial begin
    cycle_count     <= 0;
    sent            = 0;
    idle_pct        = 0;
    stall_pct       = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FUNC_ABSORB;
    in_ch.data_byte <= 8'h00;
    out_ch.ready    <= 1'b0;

    // Receiver: ready redrawn every cycle against the current stall rate.
    fork
      forever begin
        @(posedge clk);
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    join_none

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty message twice in a row (finish straight after finish),
    // the classic three-byte message, extreme byte values, and a finish whose
    // ignored data byte is all ones.
    send_request(FUNC_FINISH, 8'h00);
    send_request(FUNC_FINISH, 8'h00);
    send_request(FUNC_ABSORB, 8'h61);
    send_request(FUNC_ABSORB, 8'h62);
    send_request(FUNC_ABSORB, 8'h63);
    send_request(FUNC_FINISH, 8'hff);
    send_request(FUNC_ABSORB, 8'h00);
    send_request(FUNC_ABSORB, 8'hff);
    send_request(FUNC_FINISH, 8'h00);
    send_request(FUNC_ABSORB, 8'h80);
    send_request(FUNC_FINISH, 8'h5a);

    // Random messages in four pressure phases: clean, sender idle 70%,
    // receiver stall 70%, both at 29%.
    for (int ph = 0; ph < 4; ph++) begin
      int unsigned phase_start;
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      phase_start = sent;
      while (sent - phase_start < PHASE_REQUESTS) send_message(pick_length());
    end
    in_ch.valid <= 1'b0;

    // Let the checker's owed count see the last finish, then drain the
    // outstanding digest words and let the core settle.
    @(posedge clk);
    while (digests_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_sha256_stream_hasher_core OK");
    end else begin
      $display("tb_sha256_stream_hasher_core NOT OK");
    end
    $finish;
  end

endmodule
